>>> rtl/core/generational_handle_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// generational handle allocator assertion macros
// shared property forms for the allocator; they sample on clk and are
// disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define GHA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// types and constants of the generational handle allocator
// ----------------------------------------------------------------------------
`default_nettype none

package gha_pkg;

    localparam int unsigned X_BITS      = 5;
    localparam int unsigned Y_BITS      = 5;
    localparam int unsigned GEN_BITS    = 16;
    localparam int unsigned SLOT_BITS   = X_BITS + Y_BITS;
    localparam int unsigned SLOT_COUNT  = 1 << SLOT_BITS;
    localparam int unsigned HANDLE_BITS = GEN_BITS + SLOT_BITS;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_STALE = 2'd2;

    typedef struct packed {
        logic [1:0]             operation;
        logic [HANDLE_BITS-1:0] handle;
    } req_beat_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] result_handle;
        logic [SLOT_BITS-1:0]   slot_index;
        logic [1:0]             status;
    } rsp_beat_t;

endpackage

`default_nettype wire

>>> rtl/core/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module gha_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/generational_handle_allocator_unit.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit
// slot table of generation tags with allocate, lookup and free operations
// ----------------------------------------------------------------------------
//  channel | side   | payload               | handshake
//  req     | input  | gha_pkg::req_beat_t   | req_valid / req_stall
//  rsp     | output | gha_pkg::rsp_beat_t   | rsp_valid / rsp_stall
//
//  lookup and free read the slot in the accept cycle, check it in S_LOOK
//  and hold the result beat in S_DONE; allocate scans from the lowest-free
//  hint up to the first free slot or the high-water mark, through the single
//  read port of the slot table, one slot per cycle
//  reset is immediate: slots at or above the high-water mark read as free,
//  so the table needs no clearing pass
//  a waiting result beat does not block the next request
// ----------------------------------------------------------------------------
`default_nettype none

`include "generational_handle_allocator_unit_defines.svh"

module generational_handle_allocator_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire gha_pkg::req_beat_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output gha_pkg::rsp_beat_t      rsp
);

    localparam int unsigned SB  = gha_pkg::SLOT_BITS;
    localparam int unsigned GB  = gha_pkg::GEN_BITS;
    localparam int unsigned HB  = gha_pkg::HANDLE_BITS;
    localparam int unsigned CB  = SB + 1;
    localparam logic [CB-1:0] FULL_MARK = {1'b1, {SB{1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    logic [HB-1:0]      handle_reg, handle_next;
    logic [GB-1:0]      gen_reg, gen_next;
    logic [CB-1:0]      hw_reg, hw_next;
    logic [CB-1:0]      lf_reg, lf_next;
    logic [CB-1:0]      ptr_reg, ptr_next;
    logic               pend_reg, pend_next;
    logic [SB-1:0]      pend_idx_reg, pend_idx_next;
    gha_pkg::rsp_beat_t res_reg, res_next;
    gha_pkg::rsp_beat_t rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic               ram_we;
    logic [SB-1:0]      ram_waddr;
    logic [GB-1:0]      ram_wdata;
    logic [SB-1:0]      ram_raddr;
    logic [GB-1:0]      ram_rdata;

    logic [SB-1:0]      look_slot;
    logic [GB-1:0]      look_gen;
    logic [GB-1:0]      look_tag;
    logic               look_hit;
    logic               found;
    logic [CB-1:0]      take;
    logic [GB-1:0]      gen_inc;
    logic               rsp_load;

    gha_ram #(
        .WIDTH (GB),
        .DEPTH (gha_pkg::SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // the read is issued in the accept cycle for lookup and free
    assign ram_raddr = (state_reg == S_IDLE) ? req.handle[SB-1:0] : ptr_reg[SB-1:0];

    assign look_slot = handle_reg[SB-1:0];
    assign look_gen  = handle_reg[HB-1:SB];
    // slots at or above the high-water mark were never written and are free
    assign look_tag  = ({1'b0, look_slot} < hw_reg) ? ram_rdata : '0;
    assign look_hit  = (look_gen != '0) && (look_tag == look_gen);

    assign found   = pend_reg && (ram_rdata == '0);
    assign take    = found ? {1'b0, pend_idx_reg} : hw_reg;
    assign gen_inc = ((gen_reg + GB'(1)) == '0) ? GB'(1) : (gen_reg + GB'(1));

    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        handle_next   = handle_reg;
        gen_next      = gen_reg;
        hw_next       = hw_reg;
        lf_next       = lf_reg;
        ptr_next      = ptr_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        res_next      = res_reg;
        ram_we        = 1'b0;
        ram_waddr     = look_slot;
        ram_wdata     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req.operation;
                    handle_next = req.handle;
                    ptr_next    = lf_reg;
                    pend_next   = 1'b0;
                    state_next  = (req.operation == gha_pkg::OP_ALLOC) ? S_SCAN : S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (look_hit && (op_reg == gha_pkg::OP_FREE))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = look_slot;
                    ram_wdata = '0;
                    if ({1'b0, look_slot} < lf_reg)
                    begin
                        lf_next = {1'b0, look_slot};
                    end
                end
                res_next.result_handle = handle_reg;
                res_next.slot_index    = look_slot;
                res_next.status        = look_hit ? gha_pkg::ST_OK : gha_pkg::ST_STALE;
                state_next             = S_DONE;
            end
            S_SCAN:
            begin
                if (found || (ptr_reg >= hw_reg && !pend_reg))
                begin
                    if (!found && hw_reg == FULL_MARK)
                    begin
                        res_next.result_handle = '0;
                        res_next.slot_index    = '0;
                        res_next.status        = gha_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = take[SB-1:0];
                        ram_wdata = gen_inc;
                        gen_next  = gen_inc;
                        lf_next   = take + CB'(1);
                        if (take == hw_reg)
                        begin
                            hw_next = hw_reg + CB'(1);
                        end
                        res_next.result_handle = {gen_inc, take[SB-1:0]};
                        res_next.slot_index    = take[SB-1:0];
                        res_next.status        = gha_pkg::ST_OK;
                    end
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
                else if (ptr_reg < hw_reg)
                begin
                    // read one slot per cycle, check it the cycle after
                    pend_next     = 1'b1;
                    pend_idx_next = ptr_reg[SB-1:0];
                    ptr_next      = ptr_reg + CB'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_next       = res_reg;
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gen_reg       <= '0;
            hw_reg        <= '0;
            lf_reg        <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            hw_reg        <= hw_next;
            lf_reg        <= lf_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        handle_reg   <= handle_next;
        pend_idx_reg <= pend_idx_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    `GHA_ASSERT_NOW(a_hint_below_mark, 1'b1, lf_reg <= hw_reg, "free hint above high-water mark")
    `GHA_ASSERT_NOW(a_gen_nonzero, hw_reg != '0, gen_reg != '0, "generation zero after allocation")
    `GHA_ASSERT_NOW(a_full_only_at_mark, rsp_valid && rsp.status == gha_pkg::ST_FULL, hw_reg == FULL_MARK, "full status with free slots left")
    `GHA_ASSERT_NEXT(a_done_to_idle, rsp_load, state_reg == S_IDLE && rsp_valid_reg, "result beat not delivered on load")

endmodule

`default_nettype wire

>>> sim/gha_handle_checker.sv
// ----------------------------------------------------------------------------
// gha_handle_checker
// watches the request and result channels of the handle allocator, keeps its
// own slot tag table and tag counter, and compares every result beat with
// the oldest predicted one
// ----------------------------------------------------------------------------
module gha_handle_checker
    import gha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  req_beat_t req,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  rsp_beat_t rsp,
    output int        errors,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [GEN_BITS-1:0] slot_tags [SLOT_COUNT];
    logic [GEN_BITS-1:0] last_tag;
    rsp_beat_t           awaited_results [$];
    logic                req_taken = 1'b0;
    logic                rsp_taken = 1'b0;
    req_beat_t           req_held;
    rsp_beat_t           rsp_held;

    // ports are settled mid-cycle; the beats seen here land at the next edge
    always @(negedge clk)
    begin
        req_taken = rst_n && req_valid && !req_stall;
        rsp_taken = rst_n && rsp_valid && !rsp_stall;
        req_held  = req;
        rsp_held  = rsp;
    end

    function automatic rsp_beat_t resolve_request(req_beat_t beat);
        rsp_beat_t            outcome;
        logic [SLOT_BITS-1:0] slot;
        logic [GEN_BITS-1:0]  tag;
        logic                 found;
        logic                 hit;
        int                   s;
        outcome = '0;
        if (beat.operation == OP_ALLOC)
        begin
            found = 1'b0;
            slot  = '0;
            for (s = 0; s < SLOT_COUNT; s++)
            begin
                if (!found && slot_tags[s] == '0)
                begin
                    found = 1'b1;
                    slot  = SLOT_BITS'(s);
                end
            end
            if (found)
            begin
                tag = last_tag + 1'b1;
                // zero marks a free slot, so the counter steps over it
                if (tag == '0)
                    tag = 1;
                last_tag              = tag;
                slot_tags[slot]       = tag;
                outcome.result_handle = {tag, slot};
                outcome.slot_index    = slot;
                outcome.status        = ST_OK;
            end
            else
                outcome.status = ST_FULL;
        end
        else
        begin
            // the unused code reads like a lookup; only a free clears the tag
            slot = beat.handle[SLOT_BITS-1:0];
            tag  = beat.handle[HANDLE_BITS-1:SLOT_BITS];
            hit  = (tag != '0) && (slot_tags[slot] == tag);
            if (hit && beat.operation == OP_FREE)
                slot_tags[slot] = '0;
            outcome.result_handle = beat.handle;
            outcome.slot_index    = slot;
            outcome.status        = hit ? ST_OK : ST_STALE;
        end
        return outcome;
    endfunction

    task automatic flag_field(string field, logic [31:0] want, logic [31:0] got);
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_beat_t want;
        int        i;
        if (!rst_n)
        begin
            for (i = 0; i < SLOT_COUNT; i++)
                slot_tags[i] = '0;
            last_tag = '0;
            awaited_results.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (req_taken)
                awaited_results.push_back(resolve_request(req_held));
            if (rsp_taken)
            begin
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat 0x%0h with nothing expected, expected none",
                             $time, rsp_held);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp_held.result_handle !== want.result_handle)
                        flag_field("result_handle", want.result_handle, rsp_held.result_handle);
                    if (rsp_held.slot_index !== want.slot_index)
                        flag_field("slot_index", want.slot_index, rsp_held.slot_index);
                    if (rsp_held.status !== want.status)
                        flag_field("status", want.status, rsp_held.status);
                end
            end
            pending = awaited_results.size();
        end
    end

endmodule

>>> sim/generational_handle_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit_tb
// drives allocate, lookup and free beats into the handle allocator: a short
// directed run over the corner cases, a random run that fills the table until
// it reports full, then random churn; a checker beside the block predicts
// and compares every result beat
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gha_pkg::*;

    localparam logic [1:0] OP_UNDEFINED  = 2'd3;
    localparam int         SETTLE_CYCLES = 40;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_beat_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_beat_t rsp;
    int        errors;
    int        pending;

    logic [HANDLE_BITS-1:0] live_handles [$];
    logic [HANDLE_BITS-1:0] retired_handles [$];
    logic [1:0]             ops_in_flight [$];
    int                     full_answers = 0;
    int                     burst_left   = 0;
    int                     stall_mode   = 0;
    int                     mode_left    = 0;

    always #5 clk = ~clk;

    generational_handle_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    gha_handle_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .errors    (errors),
        .pending   (pending)
    );

    // receiver: free flow, light, heavy and periodic stall stretches
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 200);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= (mode_left % 16) < 9;
        endcase
    end

    // learn live and freed handles from result beats for later targets
    always @(negedge clk)
    begin
        logic [1:0] op;
        int         i;
        if (rst_n && rsp_valid && !rsp_stall && ops_in_flight.size() > 0)
        begin
            op = ops_in_flight.pop_front();
            if (op == OP_ALLOC && rsp.status == ST_FULL)
                full_answers++;
            else if (op == OP_ALLOC && rsp.status == ST_OK)
                live_handles.push_back(rsp.result_handle);
            else if (op == OP_FREE && rsp.status == ST_OK)
            begin
                for (i = 0; i < live_handles.size(); i++)
                begin
                    if (live_handles[i] == rsp.result_handle)
                    begin
                        live_handles.delete(i);
                        break;
                    end
                end
                retired_handles.push_back(rsp.result_handle);
            end
        end
    end

    function automatic logic [HANDLE_BITS-1:0] make_handle(logic [GEN_BITS-1:0] g,
                                                           logic [SLOT_BITS-1:0] s);
        return {g, s};
    endfunction

    // mostly live handles, then freed ones, one-bit corruptions and noise
    function automatic logic [HANDLE_BITS-1:0] pick_target();
        int                     roll;
        logic [HANDLE_BITS-1:0] h;
        roll = $urandom_range(0, 99);
        h    = HANDLE_BITS'($urandom);
        if (roll < 65 && live_handles.size() > 0)
            h = live_handles[$urandom_range(0, live_handles.size() - 1)];
        else if (roll < 78 && retired_handles.size() > 0)
            h = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
        else if (roll < 90 && live_handles.size() > 0)
        begin
            h = live_handles[$urandom_range(0, live_handles.size() - 1)];
            h ^= HANDLE_BITS'(1) << $urandom_range(0, HANDLE_BITS - 1);
        end
        return h;
    endfunction

    task automatic issue(logic [1:0] op, logic [HANDLE_BITS-1:0] h);
        int   gap;
        logic taken;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req       <= '{operation: op, handle: h};
        do
        begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end
        while (!taken);
        ops_in_flight.push_back(op);
    endtask

    task automatic random_item(int alloc_pct, int free_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct)
            issue(OP_ALLOC, HANDLE_BITS'($urandom));
        else if (roll < alloc_pct + free_pct)
            issue(OP_FREE, pick_target());
        else if (roll < 97)
            issue(OP_LOOKUP, pick_target());
        else
            issue(OP_UNDEFINED, pick_target());
    endtask

    // returns on a rising edge so the next beat is driven there
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    initial
    begin
        int guard;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // empty table: zero tag and all-ones handle both read stale
        issue(OP_LOOKUP, '0);
        issue(OP_FREE, '0);
        issue(OP_LOOKUP, '1);
        // handle bits are don't-care on allocate
        issue(OP_ALLOC, '1);
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, HANDLE_BITS'($urandom));
        issue(OP_LOOKUP, make_handle(1, 0));
        issue(OP_LOOKUP, make_handle(2, 0));
        issue(OP_UNDEFINED, make_handle(1, 0));
        issue(OP_LOOKUP, make_handle(0, 0));
        issue(OP_FREE, make_handle(2, 1));
        // second free of the same handle is stale
        issue(OP_FREE, make_handle(2, 1));
        issue(OP_LOOKUP, make_handle(2, 1));
        issue(OP_ALLOC, '0);
        issue(OP_FREE, make_handle(1, 0));
        issue(OP_FREE, make_handle(3, 2));
        issue(OP_ALLOC, '0);
        issue(OP_LOOKUP, make_handle('1, '1));
        issue(OP_UNDEFINED, '1);
        // unused code on a live handle must leave it live
        issue(OP_UNDEFINED, make_handle(5, 0));
        issue(OP_LOOKUP, make_handle(5, 0));
        issue(OP_FREE, make_handle(4, 1));
        issue(OP_FREE, make_handle(0, 2));
        req_valid <= 1'b0;
        wait_drained();

        // fill until the table answers full a few times
        guard = 0;
        while (full_answers < 4 && guard < 3000)
        begin
            random_item(88, 3);
            guard++;
        end
        req_valid <= 1'b0;
        wait_drained();

        // churn: frees open holes below the fill point, allocates refill them
        repeat (150) random_item(30, 40);
        req_valid <= 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
